// File: rtl/rslot_pkg.sv
// Shared types and constants for the record slot table.
// Used by rslot_ctrl, rslot_dpath and record_slot_table; no dependencies.
`default_nettype none

package rslot_pkg;

    localparam int DEF_ENTRIES = 64;

    localparam int CMD_W  = 2;
    localparam int ID_W   = 20;
    localparam int SEC_W  = 2;
    localparam int SAL_W  = 26;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 6;

    localparam int S_DATA_W = 48;   // id + sector + salary
    localparam int M_DATA_W = 40;   // index + sector + salary, padded to bytes
    localparam int M_PAD_W  = M_DATA_W - IDX_W - SEC_W - SAL_W;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic [ID_W-1:0]      id;
        logic [SEC_W-1:0]     sector;
        logic [SAL_W-1:0]     salary;
    } slot_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input transfer, rewind scan
        logic scan;       // issue next slot read
        logic clear_wr;   // clearing pass write
        logic take_hit;   // mark current slot as the result
        logic commit;     // write back the hit slot
        logic load_out;   // load result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_add;
        logic is_find;
        logic is_remove;
        logic hit;
        logic exhausted;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/rslot_dpath.sv
// Datapath of the record slot table: slot memory, scan counter, compare and result register.
// Depends on rslot_pkg; driven by rslot_ctrl.
`default_nettype none

module rslot_dpath
    import rslot_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [S_DATA_W-1:0] s_tdata,
    input  wire logic [CMD_W-1:0]    s_tuser,
    input  wire dp_cmd_t             cmd,
    output dp_stat_t                 stat,
    output logic [M_DATA_W-1:0]      m_tdata,
    output logic [STAT_W-1:0]        m_tuser
);

    localparam int ADDR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ENTRIES - 1);

    slot_t mem [ENTRIES];

    logic [CMD_W-1:0]    op_reg;
    logic [ID_W-1:0]     key_reg;
    logic [SEC_W-1:0]    sec_reg;
    logic [SAL_W-1:0]    sal_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                issued_all_reg;
    logic                pending_reg;
    logic                found_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    slot_t               rd_data_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0]   m_tuser_reg;

    logic                match;
    logic                issue;
    slot_t               wr_word;
    logic [STAT_W-1:0]   res_status;
    logic [IDX_W-1:0]    res_idx;
    logic [SEC_W-1:0]    res_sec;
    logic [SAL_W-1:0]    res_sal;

    assign issue = cmd.scan && !issued_all_reg;

    // free slot for add, valid id match otherwise
    assign match = (op_reg == CMD_ADD) ? !rd_data_reg.valid
                 : (rd_data_reg.valid && (rd_data_reg.id == key_reg));

    assign stat.hit        = pending_reg && match;
    assign stat.exhausted  = issued_all_reg && !pending_reg;
    assign stat.clear_last = (addr_reg == LAST_ADDR);
    assign stat.is_add     = (op_reg == CMD_ADD);
    assign stat.is_find    = (op_reg == CMD_FIND);
    assign stat.is_remove  = (op_reg == CMD_REMOVE);

    always_comb begin
        wr_word = rd_data_reg;
        wr_word.valid = 1'b0;
        if (op_reg == CMD_ADD) begin
            wr_word.valid  = 1'b1;
            wr_word.id     = key_reg;
            wr_word.sector = sec_reg;
            wr_word.salary = sal_reg;
        end
    end

    always_comb begin
        res_idx = '0;
        res_sec = '0;
        res_sal = '0;
        if (found_reg) begin
            res_status = ST_OK;
            res_idx    = IDX_W'(rd_addr_reg);
            if (op_reg != CMD_ADD) begin
                res_sec = rd_data_reg.sector;
                res_sal = rd_data_reg.salary;
            end
        end else if (op_reg == CMD_ADD) begin
            res_status = ST_FULL;
        end else begin
            res_status = ST_NOT_FOUND;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg       <= '0;
            issued_all_reg <= 1'b0;
            pending_reg    <= 1'b0;
            found_reg      <= 1'b0;
        end else if (cmd.load) begin
            addr_reg       <= '0;
            issued_all_reg <= 1'b0;
            pending_reg    <= 1'b0;
            found_reg      <= 1'b0;
        end else if (cmd.clear_wr) begin
            addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
        end else if (cmd.take_hit) begin
            found_reg <= 1'b1;
        end else if (cmd.scan) begin
            if (!issued_all_reg) begin
                pending_reg <= 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    issued_all_reg <= 1'b1;
                end else begin
                    addr_reg <= addr_reg + 1'b1;
                end
            end else begin
                pending_reg <= 1'b0;
            end
        end
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            mem[addr_reg] <= '0;
        end else if (cmd.commit) begin
            mem[rd_addr_reg] <= wr_word;
        end
        if (issue) begin
            rd_data_reg <= mem[addr_reg];
            rd_addr_reg <= addr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[ID_W-1:0];
            sec_reg <= s_tdata[ID_W +: SEC_W];
            sal_reg <= s_tdata[ID_W+SEC_W +: SAL_W];
        end
        if (cmd.load_out) begin
            m_tuser_reg <= res_status;
            m_tdata_reg <= {{M_PAD_W{1'b0}}, res_sal, res_sec, res_idx};
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

`default_nettype wire

// File: rtl/rslot_ctrl.sv
// Controller of the record slot table: clearing pass, scan sequencing and handshakes.
// Depends on rslot_pkg; commands rslot_dpath.
`default_nettype none

module rslot_ctrl
    import rslot_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        CLEAR,
        IDLE,
        SCAN,
        COMMIT,
        DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;
    logic   no_op;

    assign out_free = !out_valid_reg || m_tready;
    assign no_op    = !stat.is_add && !stat.is_find && !stat.is_remove;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) begin
                    state_next = IDLE;
                end
            end
            IDLE: begin
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = SCAN;
                end
            end
            SCAN: begin
                if (no_op) begin
                    state_next = DONE;
                end else if (stat.hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = stat.is_find ? DONE : COMMIT;
                end else if (stat.exhausted) begin
                    state_next = DONE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            COMMIT: begin
                cmd.commit = 1'b1;
                state_next = DONE;
            end
            DONE: begin
                cmd.load_out = out_free;
                if (out_free) begin
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/record_slot_table.sv
// Record slot table, top level: rslot_ctrl and rslot_dpath joined by command/status structs.
// Depends on rslot_pkg, rslot_ctrl, rslot_dpath.
//
// A table of ENTRIES record slots held in a single-port-write, registered-read memory.
// After reset the block runs a clearing pass over all ENTRIES slots with s_tready low.
// Each command scans the slots in order, one memory read per cycle, and stops at the
// first free slot (add) or first valid id match (find, remove); add and remove then
// write the slot back. The result is loaded into the output register once the scan
// ends (for unused command code 3, without a scan) and the output register is free;
// the next command can be taken as soon as the result sits in the output register, so
// the block works on one command at a time. Unused command code 3 answers not found
// without touching the table.
`default_nettype none

module record_slot_table
    import rslot_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // key_id[19:0], sector[21:20], salary_cents[47:22]
    input  wire logic [CMD_W-1:0]    s_tuser,   // cmd[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // slot_index[5:0], found_sector[7:6],
                                                // found_salary_cents[33:8], zero pad
    output logic [STAT_W-1:0]        m_tuser    // status[1:0]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rslot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rslot_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .cmd     (cmd),
        .stat    (stat),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

`ifndef SYNTHESIS
    // one command in flight: no second transfer right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a command is in flight");

    // a failed command reports slot index zero
    a_idx_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[IDX_W-1:0] == '0))
        else $error("nonzero slot index with failing status");

    // hit and exhausted are exclusive during a scan
    a_hit_or_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.hit && stat.exhausted))
        else $error("scan reports hit and exhausted together");

    // a write-back never coincides with the clearing pass
    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.commit && cmd.clear_wr))
        else $error("two slot writes in one cycle");
`endif

endmodule

`default_nettype wire
